// ===== design/task_table_round_robin_scheduler_top_defines.svh =====
// Assertion helpers for the task table scheduler
`ifndef TASK_TABLE_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH
`define TASK_TABLE_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH

// same-cycle implication
`define TTRR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// next-cycle implication
`define TTRR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== design/ttrr_pkg.sv =====
`default_nettype none
package ttrr_pkg;

    localparam int IDX_W = 8;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SCHED = 3'd1;
    localparam logic [2:0] OP_FORK  = 3'd2;
    localparam logic [2:0] OP_EXIT  = 3'd3;
    localparam logic [2:0] OP_WAIT  = 3'd4;

    localparam logic [1:0] ST_READY    = 2'd0;
    localparam logic [1:0] ST_RUNNING  = 2'd1;
    localparam logic [1:0] ST_BLOCKED  = 2'd2;
    localparam logic [1:0] ST_FINISHED = 2'd3;

    localparam logic [1:0] WM_NONE = 2'd0;
    localparam logic [1:0] WM_ALL  = 2'd1;
    localparam logic [1:0] WM_PID  = 2'd2;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FULL    = 2'd1;
    localparam logic [1:0] STS_NOCUR   = 2'd2;
    localparam logic [1:0] STS_NOREADY = 2'd3;

    localparam logic [8:0] CHILD_MAX = 9'd511;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] target_pid;
        logic        wait_all;
    } cmd_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] current_index;
        logic [31:0]      current_pid;
        logic [31:0]      new_pid;
    } result_t;

    typedef struct packed {
        logic [1:0]  state;
        logic [31:0] pid;
        logic [31:0] parent;
        logic [8:0]  children;
        logic [1:0]  wait_mode;
        logic [31:0] wait_target;
    } entry_t;

    typedef struct packed {
        logic   we;
        entry_t data;
    } wr_t;

endpackage
`default_nettype wire

// ===== design/ttrr_table_mem.sv =====
`default_nettype none
module ttrr_table_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire              clk,
    input  ttrr_pkg::wr_t    wr,
    input  wire [AW-1:0]     waddr,
    input  wire [AW-1:0]     raddr,
    output ttrr_pkg::entry_t rdata
);
    import ttrr_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[waddr] <= wr.data;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== design/ttrr_ctrl.sv =====
`default_nettype none
module ttrr_ctrl #(
    parameter int MAX_TASKS = 256,
    parameter int AW        = 8,
    parameter int CW        = 9
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  ttrr_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output ttrr_pkg::result_t result,
    output ttrr_pkg::wr_t     wr,
    output logic [AW-1:0]     waddr,
    output logic [AW-1:0]     raddr,
    input  ttrr_pkg::entry_t  rdata
);
    import ttrr_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_CUR_RD, S_CUR_CHK, S_FORK_INC, S_FIND_RD, S_FIND_CHK,
        S_WALK_RD, S_WALK_CHK, S_WALK_DECIDE, S_OUT_RD, S_OUT_CHK
    } fsm_t;

    fsm_t           state_reg, state_next;
    cmd_t           cmd_reg, cmd_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           run_valid_reg, run_valid_next;
    logic [AW-1:0]  slot_reg, slot_next;
    logic [31:0]    pidc_reg, pidc_next;
    entry_t         cur_reg, cur_next;
    entry_t         e_reg, e_next;
    logic           rel_reg, rel_next;
    logic [1:0]     status_reg, status_next;
    logic [31:0]    npid_reg, npid_next;
    logic [AW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  n_reg, n_next;
    logic [CW-1:0]  scan_reg, scan_next;
    logic           done_reg, done_next;
    result_t        result_reg, result_next;

    logic           slot_in, full, cur_ok;
    logic [CW-1:0]  slot_plus, idx_plus, scan_plus, n_plus;
    logic [31:0]    pid_adv, key;
    entry_t         fresh;

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    always_comb
    begin
        slot_in   = CW'(slot_reg) < count_reg;
        full      = count_reg >= CW'(MAX_TASKS);
        cur_ok    = run_valid_reg && slot_in && (rdata.state == ST_RUNNING);
        slot_plus = CW'(slot_reg) + CW'(1);
        idx_plus  = CW'(idx_reg) + CW'(1);
        scan_plus = scan_reg + CW'(1);
        n_plus    = n_reg + CW'(1);
        pid_adv   = pidc_reg + 32'd1;
        if (pid_adv == 32'd0)
        begin
            pid_adv = 32'd1;
        end
        key = (cmd_reg.opcode == OP_EXIT) ? cur_reg.parent : e_reg.wait_target;

        fresh             = '0;
        fresh.state       = ST_READY;
        fresh.pid         = pidc_reg;
        fresh.wait_mode   = WM_NONE;

        state_next     = state_reg;
        cmd_next       = cmd_reg;
        count_next     = count_reg;
        run_valid_next = run_valid_reg;
        slot_next      = slot_reg;
        pidc_next      = pidc_reg;
        cur_next       = cur_reg;
        e_next         = e_reg;
        rel_next       = rel_reg;
        status_next    = status_reg;
        npid_next      = npid_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        scan_next      = scan_reg;
        done_next      = 1'b0;
        result_next    = result_reg;

        wr.we   = 1'b0;
        wr.data = cur_reg;
        waddr   = slot_reg;
        raddr   = slot_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    status_next = STS_OK;
                    npid_next   = 32'd0;
                    state_next  = S_CUR_RD;
                end
            end
            S_CUR_RD:
            begin
                state_next = S_CUR_CHK;
            end
            S_CUR_CHK:
            begin
                cur_next   = rdata;
                state_next = S_OUT_RD;
                unique case (cmd_reg.opcode)
                    OP_ADD:
                    begin
                        if (full)
                        begin
                            status_next = STS_FULL;
                        end
                        else
                        begin
                            wr.we      = 1'b1;
                            wr.data    = fresh;
                            waddr      = count_reg[AW-1:0];
                            npid_next  = pidc_reg;
                            pidc_next  = pid_adv;
                            count_next = count_reg + CW'(1);
                        end
                    end
                    OP_SCHED:
                    begin
                        if (count_reg == '0)
                        begin
                            status_next = STS_NOREADY;
                        end
                        else
                        begin
                            // demote the running task, start one past it
                            if (run_valid_reg && slot_in)
                            begin
                                if (rdata.state == ST_RUNNING)
                                begin
                                    wr.we         = 1'b1;
                                    wr.data       = rdata;
                                    wr.data.state = ST_READY;
                                end
                                idx_next = (slot_plus >= count_reg) ? '0 : slot_plus[AW-1:0];
                            end
                            else
                            begin
                                idx_next = '0;
                            end
                            n_next     = '0;
                            state_next = S_WALK_RD;
                        end
                    end
                    OP_FORK:
                    begin
                        if (full)
                        begin
                            status_next = STS_FULL;
                        end
                        else if (!cur_ok)
                        begin
                            status_next = STS_NOCUR;
                        end
                        else
                        begin
                            wr.we          = 1'b1;
                            wr.data        = fresh;
                            wr.data.parent = rdata.pid;
                            waddr          = count_reg[AW-1:0];
                            npid_next      = pidc_reg;
                            pidc_next      = pid_adv;
                            count_next     = count_reg + CW'(1);
                            state_next     = S_FORK_INC;
                        end
                    end
                    OP_EXIT:
                    begin
                        if (!cur_ok)
                        begin
                            status_next = STS_NOCUR;
                        end
                        else
                        begin
                            wr.we         = 1'b1;
                            wr.data       = rdata;
                            wr.data.state = ST_FINISHED;
                            scan_next     = '0;
                            state_next    = S_FIND_RD;
                        end
                    end
                    OP_WAIT:
                    begin
                        if (!cur_ok)
                        begin
                            status_next = STS_NOCUR;
                        end
                        else
                        begin
                            wr.we         = 1'b1;
                            wr.data       = rdata;
                            wr.data.state = ST_BLOCKED;
                            if (cmd_reg.wait_all)
                            begin
                                wr.data.wait_mode   = WM_ALL;
                                wr.data.wait_target = 32'd0;
                            end
                            else
                            begin
                                wr.data.wait_mode   = WM_PID;
                                wr.data.wait_target = cmd_reg.target_pid;
                            end
                        end
                    end
                    default:
                    begin
                        status_next = STS_OK;
                    end
                endcase
            end
            S_FORK_INC:
            begin
                wr.we   = 1'b1;
                wr.data = cur_reg;
                if (cur_reg.children < CHILD_MAX)
                begin
                    wr.data.children = cur_reg.children + 9'd1;
                end
                state_next = S_OUT_RD;
            end
            S_FIND_RD:
            begin
                raddr      = scan_reg[AW-1:0];
                state_next = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                if (rdata.pid == key)
                begin
                    if (cmd_reg.opcode == OP_EXIT)
                    begin
                        if (rdata.children != 9'd0)
                        begin
                            wr.we            = 1'b1;
                            wr.data          = rdata;
                            wr.data.children = rdata.children - 9'd1;
                            waddr            = scan_reg[AW-1:0];
                        end
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        rel_next   = (rdata.state == ST_FINISHED);
                        state_next = S_WALK_DECIDE;
                    end
                end
                else if (scan_plus == count_reg)
                begin
                    // missing target counts as finished
                    rel_next   = 1'b1;
                    state_next = (cmd_reg.opcode == OP_EXIT) ? S_OUT_RD : S_WALK_DECIDE;
                end
                else
                begin
                    scan_next  = scan_plus;
                    state_next = S_FIND_RD;
                end
            end
            S_WALK_RD:
            begin
                raddr      = idx_reg;
                state_next = S_WALK_CHK;
            end
            S_WALK_CHK:
            begin
                e_next     = rdata;
                rel_next   = 1'b0;
                state_next = S_WALK_DECIDE;
                if (rdata.state == ST_BLOCKED)
                begin
                    if (rdata.wait_mode == WM_ALL)
                    begin
                        rel_next = (rdata.children == 9'd0);
                    end
                    else if (rdata.wait_mode == WM_PID)
                    begin
                        scan_next  = '0;
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_WALK_DECIDE:
            begin
                if (rel_reg || (e_reg.state == ST_READY))
                begin
                    wr.we         = 1'b1;
                    wr.data       = e_reg;
                    wr.data.state = ST_RUNNING;
                    if (rel_reg)
                    begin
                        wr.data.wait_mode = WM_NONE;
                    end
                    waddr          = idx_reg;
                    run_valid_next = 1'b1;
                    slot_next      = idx_reg;
                    status_next    = STS_OK;
                    state_next     = S_OUT_RD;
                end
                else if (n_plus == count_reg)
                begin
                    status_next = STS_NOREADY;
                    state_next  = S_OUT_RD;
                end
                else
                begin
                    n_next     = n_plus;
                    idx_next   = (idx_plus >= count_reg) ? '0 : idx_plus[AW-1:0];
                    state_next = S_WALK_RD;
                end
            end
            S_OUT_RD:
            begin
                state_next = S_OUT_CHK;
            end
            S_OUT_CHK:
            begin
                result_next.status        = status_reg;
                result_next.current_index = IDX_W'(slot_reg);
                result_next.current_pid   = cur_ok ? rdata.pid : 32'd0;
                result_next.new_pid       = npid_reg;
                done_next                 = 1'b1;
                state_next                = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            run_valid_reg <= 1'b0;
            slot_reg      <= '0;
            pidc_reg      <= 32'd1;
            done_reg      <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            run_valid_reg <= run_valid_next;
            slot_reg      <= slot_next;
            pidc_reg      <= pidc_next;
            done_reg      <= done_next;
            result_reg    <= result_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cur_reg    <= cur_next;
        e_reg      <= e_next;
        rel_reg    <= rel_next;
        status_reg <= status_next;
        npid_reg   <= npid_next;
        idx_reg    <= idx_next;
        n_reg      <= n_next;
        scan_reg   <= scan_next;
    end

endmodule
`default_nettype wire

// ===== design/task_table_round_robin_scheduler_top.sv =====
// Sequence: every command reads the current slot (CUR_RD, CUR_CHK) and ends with an output read
// (OUT_RD, OUT_CHK); fork adds FORK_INC for the parent's child count. Exit scans the table for
// the parent pid (FIND_RD, FIND_CHK per entry). Schedule walks entries (WALK_RD, WALK_CHK,
// WALK_DECIDE), plus a pid scan for each pid wait; all of it is bound by the single table read port.
// One word at a time: busy falls as done rises; the receiver cannot stall, done is one cycle.
// Reset clears count, running slot, pid counter (to 1) and control; table is not cleared.
`default_nettype none
`include "task_table_round_robin_scheduler_top_defines.svh"
module task_table_round_robin_scheduler_top #(
    parameter int MAX_TASKS = 256
) (
    input  wire               clk,
    input  wire               rst_n,
    input  wire               start,
    input  ttrr_pkg::cmd_t    cmd,
    output logic              busy,
    output logic              done,
    output ttrr_pkg::result_t result
);
    import ttrr_pkg::*;

    localparam int AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CW = $clog2(MAX_TASKS + 1);

    wr_t           wr;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    entry_t        rdata;

    ttrr_ctrl #(
        .MAX_TASKS (MAX_TASKS),
        .AW        (AW),
        .CW        (CW)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .result (result),
        .wr     (wr),
        .waddr  (waddr),
        .raddr  (raddr),
        .rdata  (rdata)
    );

    ttrr_table_mem #(
        .DEPTH (MAX_TASKS),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .wr    (wr),
        .waddr (waddr),
        .raddr (raddr),
        .rdata (rdata)
    );

    `TTRR_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
    `TTRR_ASSERT_NEXT(a_done_pulse, done, !done)
    `TTRR_ASSERT_IMPL(a_done_idle, done, !busy)
    `TTRR_ASSERT_IMPL(a_newpid_ok, done && (result.new_pid != 32'd0), result.status == STS_OK)

endmodule
`default_nettype wire
